// File: rtl/swls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swls_pkg
// Shared types, constants and state encoding for the latency statistics block.
// ----------------------------------------------------------------------------
package swls_pkg;

    localparam int LAT_W            = 24;
    localparam int CNT_W            = 7;
    localparam int SUM_W            = 31;
    localparam int DRIFT_W          = 16;
    localparam int DIV_DW           = SUM_W + 8;
    localparam int DIV_VW           = SUM_W;
    localparam int DIV_QW           = 24;
    localparam int QB_W             = 5;
    localparam int DEF_WINDOW_DEPTH = 64;
    localparam int FIFO_DEPTH       = 2;

    localparam logic [CNT_W-1:0]   LEN_RESET   = 7'd64;
    localparam logic [DRIFT_W-1:0] DRIFT_ONE   = 16'd256;
    localparam logic [DRIFT_W-1:0] DRIFT_MAX   = 16'hFFFF;
    localparam logic [QB_W-1:0]    MEAN_QBITS  = 5'd24;
    localparam logic [QB_W-1:0]    DRIFT_QBITS = 5'd16;

    // x / 100 == (x * 5243) >> 19 for x below 43699
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PCT_50      = 50;
    localparam int PCT_95      = 95;
    localparam int PCT_99      = 99;

    typedef enum logic [0:0] {
        REQ_RECORD = 1'b0,
        REQ_CLEAR  = 1'b1
    } t_swls_req_code;

    typedef struct packed {
        logic             req_type;
        logic [LAT_W-1:0] latency;
    } t_swls_in;

    typedef struct packed {
        logic [LAT_W-1:0]   median_latency;
        logic [LAT_W-1:0]   p95_latency;
        logic [LAT_W-1:0]   p99_latency;
        logic [LAT_W-1:0]   worst_latency;
        logic [LAT_W-1:0]   mean_latency;
        logic [CNT_W-1:0]   sample_count;
        logic [DRIFT_W-1:0] drift_ratio;
    } t_swls_out;

    typedef struct packed {
        logic             is_clear;
        logic [LAT_W-1:0] latency;
    } t_swls_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SETUP,
        ST_SWEEP,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_DRIFT_GO,
        ST_DRIFT_WAIT,
        ST_OUT
    } t_swls_state;

endpackage
`default_nettype wire

// File: rtl/swls_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swls_front
// Input stage: takes beats, tags record or clear, and queues them.
// ----------------------------------------------------------------------------
module swls_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire swls_pkg::t_swls_in  i_in_data,
    output logic                     o_req_valid,
    output swls_pkg::t_swls_req      o_req,
    input  wire logic                i_req_pop
);
    import swls_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_swls_req           r_q [FIFO_DEPTH];
    logic [PW-1:0]       r_wp, r_rp;
    logic [PW:0]         r_cnt;
    logic                accept;
    t_swls_req           cls;

    assign o_in_stall  = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign accept      = i_in_valid && !o_in_stall;
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rp];

    always_comb begin
        cls.is_clear = (i_in_data.req_type == REQ_CLEAR);
        cls.latency  = cls.is_clear ? '0 : i_in_data.latency;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_wp <= (r_wp == PW'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_req_pop) begin
                r_rp <= (r_rp == PW'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(accept) - (PW+1)'(i_req_pop);
        end
    end

endmodule
`default_nettype wire

// File: rtl/swls_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swls_div
// Restoring divider, one quotient bit per cycle, quotient width chosen per run.
// ----------------------------------------------------------------------------
module swls_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [swls_pkg::DIV_DW-1:0]   i_dividend,
    input  wire logic [swls_pkg::DIV_VW-1:0]   i_divisor,
    input  wire logic [swls_pkg::QB_W-1:0]     i_qbits,
    output logic                               o_done,
    output logic [swls_pkg::DIV_QW-1:0]        o_quot
);
    import swls_pkg::*;

    // caller guarantees dividend >> qbits is below the divisor
    logic [DIV_VW-1:0] r_rem;
    logic [DIV_VW-1:0] r_dvs;
    logic [DIV_DW-1:0] r_low;
    logic [DIV_QW-1:0] r_quot;
    logic [QB_W-1:0]   r_cnt;
    logic              r_busy, r_done;
    logic [DIV_VW:0]   trial;
    logic              ge;
    logic [DIV_VW:0]   diff;
    logic [5:0]        lshift;

    assign trial  = {r_rem, r_low[DIV_DW-1]};
    assign ge     = (trial >= {1'b0, r_dvs});
    assign diff   = trial - {1'b0, r_dvs};
    assign lshift = 6'(DIV_DW) - 6'(i_qbits);
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= DIV_VW'(i_dividend >> i_qbits);
            r_low  <= i_dividend << lshift;
            r_dvs  <= i_divisor;
            r_quot <= '0;
            r_cnt  <= i_qbits;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
            r_low  <= r_low << 1;
            r_quot <= {r_quot[DIV_QW-2:0], ge};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == QB_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/swls_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swls_back
// Statistics engine: ring update, sorted merge pass, sums, mean and drift.
// ----------------------------------------------------------------------------
module swls_back #(
    parameter int WINDOW_DEPTH = swls_pkg::DEF_WINDOW_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [swls_pkg::CNT_W-1:0]    i_cfg_wr_data,
    input  wire logic                          i_req_valid,
    input  wire swls_pkg::t_swls_req           i_req,
    output logic                               o_req_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output swls_pkg::t_swls_out                o_out_data
);
    import swls_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int KW = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam int SW = KW + 1;
    localparam int MW = CNT_W + 19;

    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [KW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(WINDOW_DEPTH)) begin
            s = s - SW'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    t_swls_state r_state, n_state;

    logic [LAT_W-1:0] ring  [WINDOW_DEPTH];
    logic [LAT_W-1:0] sort0 [WINDOW_DEPTH];
    logic [LAT_W-1:0] sort1 [WINDOW_DEPTH];
    logic [LAT_W-1:0] r_ring_rd, r_s0_rd, r_s1_rd;

    logic [CNT_W-1:0]   r_len, r_held, r_old_n;
    logic [AW-1:0]      r_oldest;
    logic [LAT_W-1:0]   r_worst, r_lat, r_evict_val;
    logic               r_clear, r_bank;
    logic [CNT_W-1:0]   r_idx50, r_idx95, r_idx99;
    logic [KW-1:0]      r_sh, r_wi, r_ai;
    logic               r_ins, r_rmv;
    logic [SUM_W-1:0]   r_sum, r_first, r_last;
    logic [LAT_W-1:0]   r_p50, r_p95, r_p99, r_mean;
    logic [DRIFT_W-1:0] r_drift;
    logic               r_out_valid;
    t_swls_out          r_out;

    logic [KW-1:0]      eff_len;
    logic               evict;
    logic [AW-1:0]      ring_raddr, ring_waddr;
    logic               ring_we;
    logic [LAT_W-1:0]   sort_rd;
    logic               a_avail, consume, sort_we, sort_done;
    logic [LAT_W-1:0]   sort_wval;
    logic [KW-1:0]      sort_raddr;
    logic               g_valid;
    logic [CNT_W-1:0]   quarter;
    logic               sweep_done;
    logic               out_free, out_load;
    logic               div_start, div_done;
    logic [DIV_DW-1:0]  div_dividend;
    logic [DIV_VW-1:0]  div_divisor;
    logic [QB_W-1:0]    div_qbits;
    logic [DIV_QW-1:0]  div_quot;
    logic               drift_default, drift_sat;
    logic [CNT_W-1:0]   nm1;
    logic [MW-1:0]      m50, m95, m99;

    // ---------------- combinational helpers ----------------
    always_comb begin
        if (r_len == '0) begin
            eff_len = KW'(1);
        end else if (KW'(r_len) > KW'(WINDOW_DEPTH)) begin
            eff_len = KW'(WINDOW_DEPTH);
        end else begin
            eff_len = KW'(r_len);
        end
    end

    assign evict      = (KW'(r_held) + KW'(1)) > eff_len;
    assign ring_waddr = ring_pos(r_oldest, KW'(r_held));
    assign sort_rd    = r_bank ? r_s1_rd : r_s0_rd;
    assign a_avail    = r_sh < KW'(r_old_n);
    assign g_valid    = r_ai < KW'(r_held);
    assign quarter    = r_held >> 2;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign nm1 = (r_held == '0) ? '0 : r_held - 1'b1;
    assign m50 = MW'(nm1) * MW'(PCT_50 * RECIP_100);
    assign m95 = MW'(nm1) * MW'(PCT_95 * RECIP_100);
    assign m99 = MW'(nm1) * MW'(PCT_99 * RECIP_100);

    // merge step: drop one copy of the evicted value, slot the new one in
    always_comb begin
        consume   = 1'b0;
        sort_we   = 1'b0;
        sort_wval = sort_rd;
        sort_done = 1'b0;
        if (a_avail && !r_rmv && sort_rd == r_evict_val) begin
            consume = 1'b1;
        end else if (!r_ins && (!a_avail || r_lat < sort_rd)) begin
            sort_we   = 1'b1;
            sort_wval = r_lat;
        end else if (a_avail) begin
            sort_we = 1'b1;
            consume = 1'b1;
        end else begin
            sort_done = 1'b1;
        end
    end

    assign sweep_done = sort_done && !g_valid;

    assign drift_default = (r_held < CNT_W'(4)) || (r_first == '0);
    assign drift_sat     = (DIV_DW'(r_last) >= {r_first, 8'b0});

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:       if (i_req_valid) n_state = ST_PREP;
            ST_PREP:       n_state = ST_SETUP;
            ST_SETUP:      n_state = ST_SWEEP;
            ST_SWEEP:      if (sweep_done) n_state = ST_MEAN_GO;
            ST_MEAN_GO:    n_state = (r_held == '0) ? ST_DRIFT_GO : ST_MEAN_WAIT;
            ST_MEAN_WAIT:  if (div_done) n_state = ST_DRIFT_GO;
            ST_DRIFT_GO:   n_state = (drift_default || drift_sat) ? ST_OUT : ST_DRIFT_WAIT;
            ST_DRIFT_WAIT: if (div_done) n_state = ST_OUT;
            ST_OUT:        if (out_free) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        o_req_pop    = 1'b0;
        ring_we      = 1'b0;
        ring_raddr   = r_oldest;
        sort_raddr   = r_sh;
        div_start    = 1'b0;
        div_dividend = DIV_DW'(r_sum);
        div_divisor  = DIV_VW'(r_held);
        div_qbits    = MEAN_QBITS;
        out_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_pop = i_req_valid;
            end
            ST_PREP: begin
                ring_we = !r_clear;
            end
            ST_SETUP: begin
                sort_raddr = '0;
            end
            ST_SWEEP: begin
                ring_raddr = ring_pos(r_oldest, r_ai + KW'(1));
                sort_raddr = consume ? r_sh + KW'(1) : r_sh;
            end
            ST_MEAN_GO: begin
                div_start = (r_held != '0);
            end
            ST_DRIFT_GO: begin
                div_dividend = {r_last, 8'b0};
                div_divisor  = r_first;
                div_qbits    = DRIFT_QBITS;
                div_start    = !(drift_default || drift_sat);
            end
            ST_OUT: begin
                out_load = out_free;
            end
            default: begin
                o_req_pop = 1'b0;
            end
        endcase
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring[ring_waddr] <= r_lat;
        end
        r_ring_rd <= ring[ring_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sort_we && r_state == ST_SWEEP && r_bank) begin
            sort0[r_wi[AW-1:0]] <= sort_wval;
        end
        r_s0_rd <= sort0[sort_raddr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (sort_we && r_state == ST_SWEEP && !r_bank) begin
            sort1[r_wi[AW-1:0]] <= sort_wval;
        end
        r_s1_rd <= sort1[sort_raddr[AW-1:0]];
    end

    // ---------------- divider ----------------
    swls_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_qbits    (div_qbits),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_clear <= i_req.is_clear;
                r_lat   <= i_req.latency;
            end
            ST_PREP: begin
                r_evict_val <= r_ring_rd;
                r_old_n     <= r_clear ? '0 : r_held;
                r_ins       <= r_clear;
                r_rmv       <= r_clear || !evict;
            end
            ST_SETUP: begin
                r_idx50 <= CNT_W'(m50 >> RECIP_SHIFT);
                r_idx95 <= CNT_W'(m95 >> RECIP_SHIFT);
                r_idx99 <= CNT_W'(m99 >> RECIP_SHIFT);
                r_sh    <= '0;
                r_wi    <= '0;
                r_ai    <= '0;
                r_sum   <= '0;
                r_first <= '0;
                r_last  <= '0;
                r_p50   <= '0;
                r_p95   <= '0;
                r_p99   <= '0;
                r_mean  <= '0;
                r_drift <= DRIFT_ONE;
            end
            ST_SWEEP: begin
                r_sh <= sort_raddr;
                if (consume && sort_rd == r_evict_val && !r_rmv) begin
                    r_rmv <= 1'b1;
                end
                if (sort_we) begin
                    r_wi <= r_wi + KW'(1);
                    if (sort_wval == r_lat && !r_ins && !(a_avail && !(r_lat < sort_rd))) begin
                        r_ins <= 1'b1;
                    end
                    if (r_wi == KW'(r_idx50)) r_p50 <= sort_wval;
                    if (r_wi == KW'(r_idx95)) r_p95 <= sort_wval;
                    if (r_wi == KW'(r_idx99)) r_p99 <= sort_wval;
                end
                if (g_valid) begin
                    r_ai  <= r_ai + KW'(1);
                    r_sum <= r_sum + SUM_W'(r_ring_rd);
                    if (r_ai < KW'(quarter)) begin
                        r_first <= r_first + SUM_W'(r_ring_rd);
                    end
                    if (r_ai >= KW'(r_held - quarter)) begin
                        r_last <= r_last + SUM_W'(r_ring_rd);
                    end
                end
            end
            ST_MEAN_WAIT: begin
                if (div_done) r_mean <= div_quot;
            end
            ST_DRIFT_GO: begin
                if (!drift_default && drift_sat) r_drift <= DRIFT_MAX;
            end
            ST_DRIFT_WAIT: begin
                if (div_done) r_drift <= div_quot[DRIFT_W-1:0];
            end
            default: begin
                r_lat <= r_lat;
            end
        endcase
        if (out_load) begin
            r_out.median_latency <= r_p50;
            r_out.p95_latency    <= r_p95;
            r_out.p99_latency    <= r_p99;
            r_out.worst_latency  <= r_worst;
            r_out.mean_latency   <= r_mean;
            r_out.sample_count   <= r_held;
            r_out.drift_ratio    <= r_drift;
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= LEN_RESET;
            r_held      <= '0;
            r_oldest    <= '0;
            r_worst     <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
            if (r_state == ST_PREP) begin
                if (r_clear) begin
                    r_held   <= '0;
                    r_oldest <= '0;
                    r_worst  <= '0;
                end else begin
                    if (evict) begin
                        r_oldest <= ring_pos(r_oldest, KW'(1));
                    end else begin
                        r_held <= r_held + 1'b1;
                    end
                    if (r_lat > r_worst) r_worst <= r_lat;
                end
            end
            if (out_load) begin
                r_bank      <= ~r_bank;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// File: rtl/sliding_window_latency_stats_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_latency_stats_top
// Sliding-window latency percentiles, worst, mean, count and drift tracker.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (i_in_valid / o_in_stall) carry a latency sample or a clear
//   request; each beat yields one result beat (o_out_valid / i_out_stall).
//   i_cfg_wr_en with i_cfg_wr_data sets the window length; write it only
//   while no beats are in flight.
//   A two-entry queue takes beats while the engine works on an earlier one.
//   For each item, one merge pass over the sorted copy runs alongside a
//   walk of the sample ring, then one shared radix-2 divider forms the mean
//   (24 steps) and drift (16 steps); the engine works on one item at a time.
//   Synchronous reset empties the window, clears worst and sets length 64.
//   A stalled result holds in the output register; the engine then waits
//   with its next result and the queue fills and raises o_in_stall.
// ----------------------------------------------------------------------------
module sliding_window_latency_stats_top #(
    parameter int WINDOW_DEPTH = swls_pkg::DEF_WINDOW_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [swls_pkg::CNT_W-1:0]  i_cfg_wr_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire swls_pkg::t_swls_in          i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output swls_pkg::t_swls_out              o_out_data
);
    import swls_pkg::*;

    logic      req_valid, req_pop;
    t_swls_req req;

    swls_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_pop   (req_pop)
    );

    swls_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_valid   (req_valid),
        .i_req         (req),
        .o_req_pop     (req_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_pop |-> req_valid)
        else $error("queue popped while empty");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.median_latency <= o_out_data.p95_latency) &&
                        (o_out_data.p95_latency <= o_out_data.p99_latency) &&
                        (o_out_data.p99_latency <= o_out_data.worst_latency) &&
                        (o_out_data.mean_latency <= o_out_data.worst_latency))
        else $error("percentile ordering broken");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.sample_count == '0) |->
            (o_out_data.median_latency == '0) && (o_out_data.mean_latency == '0) &&
            (o_out_data.drift_ratio == DRIFT_ONE))
        else $error("empty window result not zero");

    a_reset_open: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_in_stall && !o_out_valid)
        else $error("not idle after reset");
`endif

endmodule
`default_nettype wire

// File: sim/tb_sliding_window_latency_stats_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_latency_stats_top
// Drives latency samples and clear requests through the statistics block over
// several window lengths, predicts every result beat in-bench and compares it
// field by field, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_sliding_window_latency_stats_top;
    import swls_pkg::*;

    localparam int DEPTH     = DEF_WINDOW_DEPTH;
    localparam int EXP_DEPTH = 1024;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CNT_W-1:0]     i_cfg_wr_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_swls_in             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_swls_out            o_out_data;

    sliding_window_latency_stats_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // predictor state
    logic [LAT_W-1:0] ring_q [DEPTH];
    int unsigned      head_q;
    int unsigned      held_q;
    logic [LAT_W-1:0] worst_q;
    logic [CNT_W-1:0] win_len_q;

    // expected results, written at input accept, read at output accept
    t_swls_out   exp_mem [EXP_DEPTH];
    int unsigned exp_wr;
    int unsigned exp_rd;
    int          fail_cnt;

    function automatic logic [LAT_W-1:0] aged_sample(int unsigned i);
        return ring_q[(head_q + i) % DEPTH];
    endfunction

    function automatic t_swls_out predict_stats(t_swls_in beat);
        t_swls_out        r;
        logic [LAT_W-1:0] srt [DEPTH];
        logic [LAT_W-1:0] v;
        longint unsigned  sum, oldest, newest, drift;
        int unsigned      lim, q, j;
        lim = (win_len_q == 0) ? 1 : ((win_len_q > DEPTH) ? DEPTH : win_len_q);
        if (beat.req_type == REQ_CLEAR) begin
            held_q  = 0;
            head_q  = 0;
            worst_q = '0;
        end else begin
            ring_q[(head_q + held_q) % DEPTH] = beat.latency;
            held_q++;
            // shrunk window drops only one sample per record
            if (held_q > lim) begin
                head_q = (head_q + 1) % DEPTH;
                held_q--;
            end
            if (beat.latency > worst_q) worst_q = beat.latency;
        end
        sum = 0;
        for (int i = 0; i < held_q; i++) begin
            v = aged_sample(i);
            sum += v;
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        drift = DRIFT_ONE;
        if (held_q >= 4) begin
            q = held_q / 4;
            oldest = 0;
            newest = 0;
            for (int i = 0; i < q; i++) begin
                oldest += aged_sample(i);
                newest += aged_sample(held_q - q + i);
            end
            if (oldest != 0) begin
                drift = (newest << 8) / oldest;
                if (drift > DRIFT_MAX) drift = DRIFT_MAX;
            end
        end
        r = '0;
        if (held_q != 0) begin
            r.median_latency = srt[((held_q - 1) * PCT_50) / 100];
            r.p95_latency    = srt[((held_q - 1) * PCT_95) / 100];
            r.p99_latency    = srt[((held_q - 1) * PCT_99) / 100];
            r.mean_latency   = LAT_W'(sum / held_q);
        end
        r.worst_latency = worst_q;
        r.sample_count  = CNT_W'(held_q);
        r.drift_ratio   = DRIFT_W'(drift);
        return r;
    endfunction

    task automatic send_beat(t_swls_in beat);
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        exp_mem[exp_wr % EXP_DEPTH] = predict_stats(beat);
        exp_wr++;
        @(negedge i_clk);
        // sender works in bursts
        if ($urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '{req_type: 1'($urandom), latency: LAT_W'($urandom)};
            repeat ($urandom_range(1, 120)) @(negedge i_clk);
        end
    endtask

    task automatic drain_and_write(logic [CNT_W-1:0] len);
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        win_len_q      = len;
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else if (($urandom_range(0, 1023) & 10'h300) == 10'h300)
            i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(0, 2) == 0);
    end

    always @(posedge i_clk) begin
        t_swls_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_wr == exp_rd) begin
                $error("result beat with no expectation");
                fail_cnt++;
            end else begin
                e = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_out_data.median_latency !== e.median_latency) begin
                    $error("median_latency exp %0d got %0d", e.median_latency,
                           o_out_data.median_latency);
                    fail_cnt++;
                end
                if (o_out_data.p95_latency !== e.p95_latency) begin
                    $error("p95_latency exp %0d got %0d", e.p95_latency,
                           o_out_data.p95_latency);
                    fail_cnt++;
                end
                if (o_out_data.p99_latency !== e.p99_latency) begin
                    $error("p99_latency exp %0d got %0d", e.p99_latency,
                           o_out_data.p99_latency);
                    fail_cnt++;
                end
                if (o_out_data.worst_latency !== e.worst_latency) begin
                    $error("worst_latency exp %0d got %0d", e.worst_latency,
                           o_out_data.worst_latency);
                    fail_cnt++;
                end
                if (o_out_data.mean_latency !== e.mean_latency) begin
                    $error("mean_latency exp %0d got %0d", e.mean_latency,
                           o_out_data.mean_latency);
                    fail_cnt++;
                end
                if (o_out_data.sample_count !== e.sample_count) begin
                    $error("sample_count exp %0d got %0d", e.sample_count,
                           o_out_data.sample_count);
                    fail_cnt++;
                end
                if (o_out_data.drift_ratio !== e.drift_ratio) begin
                    $error("drift_ratio exp %0d got %0d", e.drift_ratio,
                           o_out_data.drift_ratio);
                    fail_cnt++;
                end
            end
        end
    end

    typedef struct {
        t_swls_in  beat;
        bit        known;
        t_swls_out result;
    } t_stim_row;

    localparam logic [LAT_W-1:0] LMAX = {LAT_W{1'b1}};

    // directed rows; a known result is checked against the prediction
    t_stim_row dir_rows [] = '{
        '{'{REQ_CLEAR, '0}, 1, '{0, 0, 0, 0, 0, 0, DRIFT_ONE}},
        '{'{REQ_RECORD, LMAX}, 1, '{LMAX, LMAX, LMAX, LMAX, LMAX, 1, DRIFT_ONE}},
        '{'{REQ_RECORD, '0}, 0, '{default: 0}},
        '{'{REQ_RECORD, 24'h000100}, 0, '{default: 0}},
        '{'{REQ_RECORD, 24'h555555}, 0, '{default: 0}},
        '{'{REQ_RECORD, 24'hAAAAAA}, 0, '{default: 0}},
        '{'{REQ_CLEAR, LMAX}, 1, '{0, 0, 0, 0, 0, 0, DRIFT_ONE}},
        // zero oldest quarter
        '{'{REQ_RECORD, '0}, 0, '{default: 0}},
        '{'{REQ_RECORD, 24'd5}, 0, '{default: 0}},
        '{'{REQ_RECORD, 24'd9}, 0, '{default: 0}},
        '{'{REQ_RECORD, 24'd3}, 0, '{default: 0}},
        '{'{REQ_CLEAR, '0}, 0, '{default: 0}},
        // saturating drift
        '{'{REQ_RECORD, 24'd1}, 0, '{default: 0}},
        '{'{REQ_RECORD, LMAX}, 0, '{default: 0}},
        '{'{REQ_RECORD, LMAX}, 0, '{default: 0}},
        '{'{REQ_RECORD, LMAX}, 0, '{default: 0}}
    };

    task automatic random_phase(int n, int unsigned lat_hi);
        t_swls_in b;
        for (int i = 0; i < n; i++) begin
            b.req_type = ($urandom_range(0, 39) == 0) ? REQ_CLEAR : REQ_RECORD;
            case ($urandom_range(0, 3))
                0:       b.latency = LAT_W'($urandom);
                1:       b.latency = LAT_W'($urandom_range(0, lat_hi));
                2:       b.latency = ($urandom_range(0, 1)) ? LMAX : '0;
                default: b.latency = LAT_W'($urandom_range(0, 4095));
            endcase
            send_beat(b);
        end
    endtask

    initial begin
        t_swls_out p;
        fail_cnt      = 0;
        exp_wr        = 0;
        exp_rd        = 0;
        head_q        = 0;
        held_q        = 0;
        worst_q       = '0;
        win_len_q     = LEN_RESET;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            send_beat(dir_rows[k].beat);
            p = exp_mem[(exp_wr - 1) % EXP_DEPTH];
            if (dir_rows[k].known && p != dir_rows[k].result) begin
                $error("directed row %0d: predicted result differs from table", k);
                fail_cnt++;
            end
        end

        random_phase(150, 255);
        drain_and_write(7'd4);       // shrink from the reset length
        random_phase(80, 65535);
        drain_and_write(7'd1);
        random_phase(40, 1000);
        drain_and_write(7'd0);       // zero length acts as one
        random_phase(30, 1000);
        drain_and_write(7'd127);     // saturates to full depth
        random_phase(150, 255);
        drain_and_write(7'd13);
        random_phase(100, 4095);
        drain_and_write(7'd64);
        random_phase(100, 1 << 20);

        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_cnt == 0) $display("tb_sliding_window_latency_stats_top OK");
        else $display("tb_sliding_window_latency_stats_top NOT OK");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_sliding_window_latency_stats_top NOT OK");
        $finish;
    end

endmodule

// File: sim.f
rtl/swls_pkg.sv
rtl/swls_front.sv
rtl/swls_div.sv
rtl/swls_back.sv
rtl/sliding_window_latency_stats_top.sv
sim/tb_sliding_window_latency_stats_top.sv
